// ===== design/dbpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbpc_pkg
// Shared widths, constants and state type for the dual button classifier.
// ----------------------------------------------------------------------------
package dbpc_pkg;

  localparam int NOW_W   = 32;  // timestamp port width
  localparam int LONG_W  = 16;  // long press threshold register
  localparam int SECS_W  = 8;   // restart hold seconds register
  localparam int MS_W    = 10;  // width of the ms-per-second constant
  localparam int PCT_W   = 7;   // percent field and quotient width
  localparam int ELAP_W  = SECS_W + MS_W;  // holds secs * 1000
  localparam int PROD_W  = ELAP_W + PCT_W; // elapsed * 100
  localparam int DSTEP_W = $clog2(PCT_W);
  localparam int CFG_AW  = 1;
  localparam int CFG_DW  = 16;

  localparam logic [LONG_W-1:0] LONG_RST = 16'd500;
  localparam logic [SECS_W-1:0] SECS_RST = 8'd3;
  localparam logic [MS_W-1:0]   MS_PER_S = 10'd1000;
  localparam logic [PCT_W-1:0]  PCT_FULL = 7'd100;
  localparam logic [PCT_W-1:0]  PCT_NONE = 7'd0;

  localparam logic [CFG_AW-1:0] CFG_LONG = 1'b0;
  localparam logic [CFG_AW-1:0] CFG_SECS = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SER,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } state_t;

endpackage

// ===== design/dual_button_press_classifier.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_button_press_classifier
// Two-button short/long/hazard classifier with a boot-hold restart prompt.
// ----------------------------------------------------------------------------
// Requests do not overlap: in_stall holds from accept through the bit-serial
//   time subtract pass (SER_N = max(TIME_BITS, 18) bits) and seven restoring
//   divide steps until the result enters the result register, which waits
//   while out_stall holds a previous result there.
// Reset (rst_n low, synchronous): buttons seen released, no hazard, no
//   prompt, times zero, thresholds 500 ms and 3 s, no result pending.
// ----------------------------------------------------------------------------
module dual_button_press_classifier
  import dbpc_pkg::*;
#(
  parameter int TIME_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  // request channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_left_level,
  input  logic              in_right_level,
  input  logic              in_boot_pressed,
  input  logic [NOW_W-1:0]  in_now_ms,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_hazard_start,
  output logic              out_left_short,
  output logic              out_left_long,
  output logic              out_right_short,
  output logic              out_right_long,
  output logic              out_prompt_active,
  output logic              out_prompt_closed,
  output logic [PCT_W-1:0]  out_progress_percent,
  output logic              out_restart_request,
  // configuration
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  // Serial pass covers the whole time word and at least the elapsed
  // capture window, so a narrow time base still yields 18 elapsed bits.
  localparam int SER_N = (TIME_BITS > ELAP_W) ? TIME_BITS : ELAP_W;
  localparam int CNT_W = $clog2(SER_N + 1);

  state_t state_r, state_nxt;

  // configuration
  logic [LONG_W-1:0] long_r;
  logic [SECS_W-1:0] secs_r;

  // architectural state
  logic                 last_left_r, last_right_r;
  logic                 left_done_r, right_done_r;
  logic                 hazard_r, prompt_on_r;
  logic [TIME_BITS-1:0] lpt_r, rpt_r, pst_r;

  // per-request flags settled at accept time
  logic hz_r, ls_r, rs_r, lchk_r, rchk_r, prompt_mid_r, boot_r;

  // serial datapath
  logic [CNT_W-1:0]     cnt_r;
  logic [TIME_BITS-1:0] now_sh_r;
  logic [LONG_W-1:0]    long_sh_r;
  logic [ELAP_W-1:0]    req_sh_r, req_r, elap_r;
  logic                 bl_r, br_r, bp_r;   // borrows
  logic                 gt_l_r, gt_r_r, ge_r;

  // divider
  logic [PROD_W-1:0]  rem_r, dvs_r;
  logic [PCT_W-1:0]   quo_r;
  logic [DSTEP_W-1:0] dstep_r;

  // result register
  logic             out_valid_r;
  logic             o_hz_r, o_ls_r, o_ll_r, o_rs_r, o_rl_r;
  logic             o_act_r, o_cls_r, o_rst_r;
  logic [PCT_W-1:0] o_pct_r;

  // --------------------------------------------------------------------------
  // Accept-time decisions: hazard entry/exit, press and release edges.
  // --------------------------------------------------------------------------
  logic                 acc, fin_go;
  logic                 both_dn, hz_a, haz_a;
  logic                 ldone_h, l_edge, l_press, ls_a, ldone_a, lchk_a;
  logic                 rdone_h, r_edge, r_press, rs_a, rdone_a, rchk_a;
  logic                 p_start;
  logic [TIME_BITS-1:0] now_t;
  logic [ELAP_W-1:0]    required;

  always_comb begin
    acc      = in_valid && !in_stall;
    fin_go   = (state_r == ST_FIN) && (!out_valid_r || !out_stall);
    now_t    = TIME_BITS'(in_now_ms);
    both_dn  = !in_left_level && !in_right_level;
    hz_a     = both_dn && !hazard_r;
    haz_a    = both_dn ? 1'b1 : ((in_left_level && in_right_level) ? 1'b0 : hazard_r);

    // hazard entry marks both handled; a press edge in the same sample
    // clears the flag again
    ldone_h  = hz_a || left_done_r;
    l_edge   = in_left_level != last_left_r;
    l_press  = l_edge && !in_left_level;
    ls_a     = l_edge && in_left_level && !ldone_h && !haz_a;
    ldone_a  = l_press ? 1'b0 : ldone_h;
    lchk_a   = !in_left_level && !ldone_a && !haz_a;

    rdone_h  = hz_a || right_done_r;
    r_edge   = in_right_level != last_right_r;
    r_press  = r_edge && !in_right_level;
    rs_a     = r_edge && in_right_level && !rdone_h && !haz_a;
    rdone_a  = r_press ? 1'b0 : rdone_h;
    rchk_a   = !in_right_level && !rdone_a && !haz_a;

    p_start  = in_boot_pressed && !prompt_on_r;
    required = ELAP_W'(secs_r) * ELAP_W'(MS_PER_S);
  end

  // --------------------------------------------------------------------------
  // One bit per cycle, LSB first: three subtractors (now minus press/start
  // time) and three running magnitude compares.
  // --------------------------------------------------------------------------
  logic tb, nb, xl, xr, xp, dl, dr, dp, kb, qb;

  always_comb begin
    tb = cnt_r < CNT_W'(TIME_BITS);
    nb = now_sh_r[0] && tb;
    xl = lpt_r[0] && tb;
    xr = rpt_r[0] && tb;
    xp = pst_r[0] && tb;
    // bits past the time width are zero: the difference wraps
    dl = tb && (nb ^ xl ^ bl_r);
    dr = tb && (nb ^ xr ^ br_r);
    dp = tb && (nb ^ xp ^ bp_r);
    kb = long_sh_r[0];
    qb = req_sh_r[0];
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_stall  = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (acc) state_nxt = ST_SER;
      end
      ST_SER: begin
        if (cnt_r == CNT_W'(SER_N - 1)) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (dstep_r == DSTEP_W'(PCT_W - 1)) state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (fin_go) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_r <= LONG_RST;
      secs_r <= SECS_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_LONG: long_r <= cfg_wdata;
        CFG_SECS: secs_r <= cfg_wdata[SECS_W-1:0];
        default:  ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Button and prompt state
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_left_r  <= 1'b1;
      last_right_r <= 1'b1;
      left_done_r  <= 1'b0;
      right_done_r <= 1'b0;
      hazard_r     <= 1'b0;
      prompt_on_r  <= 1'b0;
      lpt_r        <= '0;
      rpt_r        <= '0;
      pst_r        <= '0;
    end else if (acc) begin
      last_left_r  <= in_left_level;
      last_right_r <= in_right_level;
      left_done_r  <= ldone_a;
      right_done_r <= rdone_a;
      hazard_r     <= haz_a;
      prompt_on_r  <= in_boot_pressed;
      if (l_press) lpt_r <= now_t;
      if (r_press) rpt_r <= now_t;
      if (p_start) pst_r <= now_t;
    end else if (state_r == ST_SER && tb) begin
      // rotate: a full pass returns each time word to its place
      lpt_r <= {lpt_r[0], lpt_r[TIME_BITS-1:1]};
      rpt_r <= {rpt_r[0], rpt_r[TIME_BITS-1:1]};
      pst_r <= {pst_r[0], pst_r[TIME_BITS-1:1]};
    end else if (fin_go) begin
      if (lchk_r && gt_l_r) left_done_r  <= 1'b1;
      if (rchk_r && gt_r_r) right_done_r <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Datapath: accept latch, serial pass, scale by 100, restoring divide
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          hz_r         <= hz_a;
          ls_r         <= ls_a;
          rs_r         <= rs_a;
          lchk_r       <= lchk_a;
          rchk_r       <= rchk_a;
          prompt_mid_r <= in_boot_pressed || prompt_on_r;
          boot_r       <= in_boot_pressed;
          now_sh_r     <= now_t;
          long_sh_r    <= long_r;
          req_sh_r     <= required;
          req_r        <= required;
          bl_r         <= 1'b0;
          br_r         <= 1'b0;
          bp_r         <= 1'b0;
          gt_l_r       <= 1'b0;
          gt_r_r       <= 1'b0;
          ge_r         <= 1'b1;  // equal counts as reached
          cnt_r        <= '0;
        end
      end
      ST_SER: begin
        bl_r      <= (!nb && xl) || (!(nb ^ xl) && bl_r);
        br_r      <= (!nb && xr) || (!(nb ^ xr) && br_r);
        bp_r      <= (!nb && xp) || (!(nb ^ xp) && bp_r);
        if (dl != kb) gt_l_r <= dl;
        if (dr != kb) gt_r_r <= dr;
        if (dp != qb) ge_r   <= dp;
        now_sh_r  <= now_sh_r >> 1;
        long_sh_r <= long_sh_r >> 1;
        req_sh_r  <= req_sh_r >> 1;
        if (cnt_r < CNT_W'(ELAP_W)) elap_r <= {dp, elap_r[ELAP_W-1:1]};
        cnt_r     <= cnt_r + 1'b1;
      end
      ST_MUL: begin
        // only used when elapsed < required, so elapsed fits ELAP_W bits
        rem_r   <= PROD_W'(elap_r) * PROD_W'(PCT_FULL);
        dvs_r   <= PROD_W'(req_r) << (PCT_W - 1);
        quo_r   <= '0;
        dstep_r <= '0;
      end
      ST_DIV: begin
        if (rem_r >= dvs_r) begin
          rem_r <= rem_r - dvs_r;
          quo_r <= {quo_r[PCT_W-2:0], 1'b1};
        end else begin
          quo_r <= {quo_r[PCT_W-2:0], 1'b0};
        end
        dvs_r   <= dvs_r >> 1;
        dstep_r <= dstep_r + 1'b1;
      end
      ST_FIN: ;
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Result register: frees the sequencer while a result waits
  // --------------------------------------------------------------------------
  logic [PCT_W-1:0] pct_f;

  always_comb begin
    if (!prompt_mid_r) pct_f = PCT_NONE;
    else if (ge_r)     pct_f = PCT_FULL;
    else               pct_f = quo_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      o_hz_r  <= hz_r;
      o_ls_r  <= ls_r;
      o_rs_r  <= rs_r;
      o_ll_r  <= lchk_r && gt_l_r;
      o_rl_r  <= rchk_r && gt_r_r;
      o_act_r <= prompt_mid_r && boot_r;
      o_cls_r <= prompt_mid_r && !boot_r;
      o_pct_r <= pct_f;
      o_rst_r <= prompt_mid_r && boot_r && ge_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_hazard_start     = o_hz_r;
  assign out_left_short       = o_ls_r;
  assign out_left_long        = o_ll_r;
  assign out_right_short      = o_rs_r;
  assign out_right_long       = o_rl_r;
  assign out_prompt_active    = o_act_r;
  assign out_prompt_closed    = o_cls_r;
  assign out_progress_percent = o_pct_r;
  assign out_restart_request  = o_rst_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_restart_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_restart_request) |->
      (out_prompt_active && out_progress_percent == PCT_FULL))
    else $error("restart without full progress");

  a_prompt_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_prompt_active && out_prompt_closed))
    else $error("prompt both active and closed");

  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_progress_percent <= PCT_FULL))
    else $error("progress above full");

  a_hazard_no_long: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hazard_start) |-> !(out_left_long || out_right_long))
    else $error("long press in hazard sample");

  a_short_long_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_left_short && out_left_long) &&
                  !(out_right_short && out_right_long))
    else $error("short and long on one button");

  a_serial_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SER && cnt_r == CNT_W'(SER_N - 1)) |=> (state_r == ST_MUL))
    else $error("serial pass length");

endmodule

// ===== dv/press_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// press_result_checker
// Watches the request, result and register ports of the button classifier,
// predicts each result from its own copy of the press state and compares.
// ----------------------------------------------------------------------------
module press_result_checker
  import dbpc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic              in_left_level,
  input  logic              in_right_level,
  input  logic              in_boot_pressed,
  input  logic [NOW_W-1:0]  in_now_ms,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic              out_hazard_start,
  input  logic              out_left_short,
  input  logic              out_left_long,
  input  logic              out_right_short,
  input  logic              out_right_long,
  input  logic              out_prompt_active,
  input  logic              out_prompt_closed,
  input  logic [PCT_W-1:0]  out_progress_percent,
  input  logic              out_restart_request,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_DW-1:0] cfg_wdata,
  output int                n_fail,
  output int                n_pending,
  output int                n_checked,
  output int                n_hazard,
  output int                n_short,
  output int                n_long,
  output int                n_restart
);

  typedef struct packed {
    logic             hazard_start;
    logic             left_short;
    logic             left_long;
    logic             right_short;
    logic             right_long;
    logic             prompt_active;
    logic             prompt_closed;
    logic [PCT_W-1:0] progress_percent;
    logic             restart_request;
  } press_result_t;

  typedef struct packed {
    logic             last;
    logic [NOW_W-1:0] t_press;
    logic             done;
    logic             short_ev;
    logic             long_ev;
  } button_track_t;

  press_result_t     expected_results[$];

  logic [LONG_W-1:0] long_ms;
  logic [SECS_W-1:0] hold_s;
  button_track_t     left_btn, right_btn;
  logic              hazard_on, prompt_on;
  logic [NOW_W-1:0]  prompt_t0;

  int fail_cnt, check_cnt, hz_cnt, short_cnt, long_cnt, restart_cnt;

  function automatic button_track_t track_button(input logic level,
                                                 input button_track_t cur,
                                                 input logic [NOW_W-1:0] now);
    button_track_t    nxt;
    logic [NOW_W-1:0] held;
    nxt          = cur;
    nxt.short_ev = 1'b0;
    nxt.long_ev  = 1'b0;
    if (level != cur.last) begin
      if (!level) begin
        nxt.t_press = now;
        nxt.done    = 1'b0;
      end else if (!cur.done && !hazard_on) begin
        nxt.short_ev = 1'b1;
      end
      nxt.last = level;
    end
    held = now - nxt.t_press;  // wraps mod 2^32
    if (!level && !nxt.done && !hazard_on && held > long_ms) begin
      nxt.long_ev = 1'b1;
      nxt.done    = 1'b1;
    end
    return nxt;
  endfunction

  task automatic classify(input logic lvl_l, input logic lvl_r, input logic boot,
                          input logic [NOW_W-1:0] now, output press_result_t res);
    logic [NOW_W-1:0] elapsed;
    logic [63:0]      el64, need, pct;
    res = '0;
    if (!lvl_l && !lvl_r) begin
      if (!hazard_on) begin
        res.hazard_start = 1'b1;
        hazard_on        = 1'b1;
        left_btn.done    = 1'b1;
        right_btn.done   = 1'b1;
      end
    end else if (lvl_l && lvl_r) begin
      hazard_on = 1'b0;
    end
    left_btn        = track_button(lvl_l, left_btn, now);
    right_btn       = track_button(lvl_r, right_btn, now);
    res.left_short  = left_btn.short_ev;
    res.left_long   = left_btn.long_ev;
    res.right_short = right_btn.short_ev;
    res.right_long  = right_btn.long_ev;

    if (boot && !prompt_on) begin
      prompt_on = 1'b1;
      prompt_t0 = now;
    end
    if (prompt_on) begin
      elapsed = now - prompt_t0;
      el64    = elapsed;
      need    = hold_s * 64'd1000;
      // zero seconds lands here too: no divide
      if (el64 >= need) pct = 64'd100;
      else pct = (el64 * 64'd100) / need;
      res.progress_percent = pct[PCT_W-1:0];
      if (!boot) begin
        prompt_on         = 1'b0;
        res.prompt_closed = 1'b1;
      end else begin
        res.prompt_active   = 1'b1;
        res.restart_request = (pct >= 64'd100);
      end
    end
  endtask

  function automatic string result_text(input press_result_t r);
    return $sformatf("hz=%b ls=%b ll=%b rs=%b rl=%b act=%b cls=%b pct=%0d rst=%b",
                     r.hazard_start, r.left_short, r.left_long, r.right_short,
                     r.right_long, r.prompt_active, r.prompt_closed,
                     r.progress_percent, r.restart_request);
  endfunction

  always @(posedge clk) begin : watch
    press_result_t exp_r, got_r;
    if (!rst_n) begin
      long_ms       = LONG_RST;
      hold_s        = SECS_RST;
      left_btn      = '0;
      left_btn.last = 1'b1;
      right_btn     = left_btn;
      hazard_on     = 1'b0;
      prompt_on     = 1'b0;
      prompt_t0     = '0;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_LONG: long_ms = cfg_wdata[LONG_W-1:0];
          CFG_SECS: hold_s  = cfg_wdata[SECS_W-1:0];
          default: ;
        endcase
      end

      // results first: a result never belongs to a request taken this edge
      if (out_valid && !out_stall) begin
        got_r = {out_hazard_start, out_left_short, out_left_long, out_right_short,
                 out_right_long, out_prompt_active, out_prompt_closed,
                 out_progress_percent, out_restart_request};
        if (expected_results.size() == 0) begin
          if (fail_cnt < 10)
            $display("[%0t] ERROR: result with no request outstanding: %s",
                     $realtime, result_text(got_r));
          fail_cnt++;
        end else begin
          exp_r = expected_results.pop_front();
          check_cnt++;
          if (got_r !== exp_r) begin
            if (fail_cnt < 10) begin
              $display("[%0t] ERROR: result %0d mismatch", $realtime, check_cnt);
              $display("  expected %s", result_text(exp_r));
              $display("  actual   %s", result_text(got_r));
            end
            fail_cnt++;
          end
        end
      end

      if (in_valid && !in_stall) begin
        classify(in_left_level, in_right_level, in_boot_pressed, in_now_ms, exp_r);
        expected_results.push_back(exp_r);
        hz_cnt      += exp_r.hazard_start;
        short_cnt   += exp_r.left_short + exp_r.right_short;
        long_cnt    += exp_r.left_long + exp_r.right_long;
        restart_cnt += exp_r.restart_request;
      end
    end
    n_fail    <= fail_cnt;
    n_pending <= expected_results.size();
    n_checked <= check_cnt;
    n_hazard  <= hz_cnt;
    n_short   <= short_cnt;
    n_long    <= long_cnt;
    n_restart <= restart_cnt;
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the dual button classifier: directed press,
// hazard and boot-hold sequences, then random button walks under several
// threshold settings with random request gaps and result back-pressure.
// ----------------------------------------------------------------------------
module tb_top
  import dbpc_pkg::*;
();

  localparam int CYCLE_LIMIT = 500000;  // watchdog bound for the whole run
  localparam int SETTLE_CYC  = 4;       // pause before a register write
  localparam int END_CYC     = 60;      // idle tail after the final drain

  logic              clk             = 1'b0;
  logic              rst_n           = 1'b0;
  logic              in_valid        = 1'b0;
  logic              in_stall;
  logic              in_left_level   = 1'b1;
  logic              in_right_level  = 1'b1;
  logic              in_boot_pressed = 1'b0;
  logic [NOW_W-1:0]  in_now_ms       = '0;
  logic              out_valid;
  logic              out_stall       = 1'b0;
  logic              out_hazard_start;
  logic              out_left_short;
  logic              out_left_long;
  logic              out_right_short;
  logic              out_right_long;
  logic              out_prompt_active;
  logic              out_prompt_closed;
  logic [PCT_W-1:0]  out_progress_percent;
  logic              out_restart_request;
  logic              cfg_we          = 1'b0;
  logic [CFG_AW-1:0] cfg_addr        = CFG_LONG;
  logic [CFG_DW-1:0] cfg_wdata       = '0;

  int n_fail, n_pending, n_checked, n_hazard, n_short, n_long, n_restart;

  // Idle odds in percent: the sender's is used only by the stimulus process,
  // the receiver's is read by the stall process and so changes by NBA.
  int                snd_idle   = 21;
  int                rcv_idle   = 80;
  int unsigned       cycle_cnt  = 0;
  int                n_sent     = 0;
  int                n_settings = 1;  // reset values count as the first setting

  logic [NOW_W-1:0]  clock_ms;        // base timestamp; the next request carries it plus its gap
  logic [LONG_W-1:0] cur_long;        // thresholds last written, to aim gaps
  logic [SECS_W-1:0] cur_secs;
  logic              lvl_l, lvl_r, lvl_b;  // random walk of the pins

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  dual_button_press_classifier dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_left_level        (in_left_level),
    .in_right_level       (in_right_level),
    .in_boot_pressed      (in_boot_pressed),
    .in_now_ms            (in_now_ms),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_hazard_start     (out_hazard_start),
    .out_left_short       (out_left_short),
    .out_left_long        (out_left_long),
    .out_right_short      (out_right_short),
    .out_right_long       (out_right_long),
    .out_prompt_active    (out_prompt_active),
    .out_prompt_closed    (out_prompt_closed),
    .out_progress_percent (out_progress_percent),
    .out_restart_request  (out_restart_request),
    .cfg_we               (cfg_we),
    .cfg_addr             (cfg_addr),
    .cfg_wdata            (cfg_wdata)
  );

  press_result_checker chk (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_left_level        (in_left_level),
    .in_right_level       (in_right_level),
    .in_boot_pressed      (in_boot_pressed),
    .in_now_ms            (in_now_ms),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_hazard_start     (out_hazard_start),
    .out_left_short       (out_left_short),
    .out_left_long        (out_left_long),
    .out_right_short      (out_right_short),
    .out_right_long       (out_right_long),
    .out_prompt_active    (out_prompt_active),
    .out_prompt_closed    (out_prompt_closed),
    .out_progress_percent (out_progress_percent),
    .out_restart_request  (out_restart_request),
    .cfg_we               (cfg_we),
    .cfg_addr             (cfg_addr),
    .cfg_wdata            (cfg_wdata),
    .n_fail               (n_fail),
    .n_pending            (n_pending),
    .n_checked            (n_checked),
    .n_hazard             (n_hazard),
    .n_short              (n_short),
    .n_long               (n_long),
    .n_restart            (n_restart)
  );

  // Result back-pressure: a fresh coin every cycle.
  always @(posedge clk)
    out_stall <= ($urandom_range(99, 0) < rcv_idle);

  // Watchdog.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Advance the timestamp by gap and hand one pin sample to the block. The
  // sender may idle first; once valid is up the payload holds until taken.
  // in_stall is read just after the edge, so it is the value the block used.
  task automatic sample(input logic l, input logic r, input logic b,
                        input logic [NOW_W-1:0] gap);
    clock_ms = clock_ms + gap;
    while ($urandom_range(99, 0) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_left_level   <= l;
    in_right_level  <= r;
    in_boot_pressed <= b;
    in_now_ms       <= clock_ms;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_sent++;
  endtask

  // Drop valid and wait for every outstanding result. The first edge lets the
  // checker's count catch up with a request taken on the current edge.
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // Both registers back to back; write enable stays high across the pair.
  // Upper data bits of the seconds write are junk the block must ignore.
  task automatic apply_cfg(input logic [LONG_W-1:0] long_v, input logic [SECS_W-1:0] secs_v);
    drain();
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_LONG;
    cfg_wdata <= long_v;
    @(posedge clk);
    cfg_addr  <= CFG_SECS;
    cfg_wdata <= {8'($urandom), secs_v};
    @(posedge clk);
    cfg_we    <= 1'b0;
    cur_long  = long_v;
    cur_secs  = secs_v;
    n_settings++;
  endtask

  // Random pin walk. Mostly real press/hold/release sequences with gaps aimed
  // at the long-press threshold and the restart hold, some pure noise. Each
  // call runs through the three idling regimes in thirds.
  task automatic rand_items(input int n);
    logic [NOW_W-1:0] gap;
    int               pick;
    for (int i = 0; i < n; i++) begin
      case (i * 3 / n)
        0:       begin snd_idle = 21; rcv_idle <= 80; end
        1:       begin snd_idle = 80; rcv_idle <= 21; end
        default: begin snd_idle = 0;  rcv_idle <= 0;  end
      endcase

      pick = $urandom_range(99, 0);
      if (pick < 10) begin
        lvl_l = 1'($urandom);
        lvl_r = 1'($urandom);
        lvl_b = 1'($urandom);
      end else begin
        if (pick < 20) begin
          // both side buttons move together: hazard entry and exit
          lvl_l = ~lvl_l;
          lvl_r = ~lvl_r;
        end else begin
          if ($urandom_range(99, 0) < 30) lvl_l = ~lvl_l;
          if ($urandom_range(99, 0) < 30) lvl_r = ~lvl_r;
        end
        if ($urandom_range(99, 0) < 15) lvl_b = ~lvl_b;
      end

      pick = $urandom_range(99, 0);
      if (pick < 40)
        gap = $urandom_range(300, 0);
      else if (pick < 65)
        gap = (cur_long < 3) ? $urandom_range(6, 0) : cur_long - 3 + $urandom_range(6, 0);
      else if (pick < 85)
        gap = $urandom_range(cur_secs * 500 + 200, 0);
      else if (pick < 95)
        gap = $urandom_range(32'h000F_FFFF, 0);
      else
        gap = $urandom;  // big jumps: wraps and every timestamp bit
      sample(lvl_l, lvl_r, lvl_b, gap);
    end
  endtask

  initial begin
    clock_ms = '0;
    cur_long = LONG_RST;
    cur_secs = SECS_RST;
    lvl_l    = 1'b1;
    lvl_r    = 1'b1;
    lvl_b    = 1'b0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // ---- directed, reset thresholds (500 ms, 3 s) ----
    sample(1'b1, 1'b1, 1'b0, 0);     // quiet, no prompt: percent 0
    sample(1'b0, 1'b1, 1'b0, 10);    // left press
    sample(1'b0, 1'b1, 1'b0, 500);   // held exactly the threshold: nothing
    sample(1'b0, 1'b1, 1'b0, 1);     // one past: left long
    sample(1'b1, 1'b1, 1'b0, 20);    // release after long: no short
    sample(1'b1, 1'b0, 1'b0, 30);    // right press
    sample(1'b1, 1'b1, 1'b0, 200);   // right short
    sample(1'b0, 1'b0, 1'b0, 30);    // simultaneous press: hazard, edges reopen both
    sample(1'b0, 1'b0, 1'b0, 900);   // hazard blocks long presses
    sample(1'b1, 1'b1, 1'b0, 10);    // both released: hazard off, two shorts
    sample(1'b0, 1'b1, 1'b0, 10);    // left first
    sample(1'b0, 1'b0, 1'b0, 10);    // right joins: hazard, only right reopened
    sample(1'b1, 1'b0, 1'b0, 600);   // left released under hazard
    sample(1'b1, 1'b1, 1'b0, 10);    // right released: right short
    sample(1'b1, 1'b1, 1'b1, 10);    // boot held: prompt at 0
    sample(1'b1, 1'b1, 1'b1, 1500);  // 50 percent
    sample(1'b1, 1'b1, 1'b1, 1499);  // 99 percent
    sample(1'b1, 1'b1, 1'b1, 1);     // 100: restart
    sample(1'b1, 1'b1, 1'b1, 700);   // restart repeats while held
    sample(1'b1, 1'b1, 1'b0, 5);     // closing sample keeps its percent
    clock_ms = 32'hFFFF_FF00;        // timestamp wrap under a held button
    sample(1'b0, 1'b1, 1'b1, 0);
    sample(1'b0, 1'b1, 1'b1, 512);
    sample(1'b1, 1'b1, 1'b0, 1);
    clock_ms = 32'hFFFF_FFFF;
    sample(1'b1, 1'b1, 1'b0, 0);
    rand_items(150);

    // ---- zero thresholds: long after 1 ms, restart on first held sample ----
    apply_cfg(16'd0, 8'd0);
    snd_idle = 21;
    rcv_idle <= 80;
    sample(1'b0, 1'b1, 1'b1, 1);
    sample(1'b0, 1'b1, 1'b1, 1);
    sample(1'b1, 1'b1, 1'b0, 1);
    lvl_l = 1'b1;
    lvl_r = 1'b1;
    lvl_b = 1'b0;
    rand_items(100);

    // ---- top thresholds, timestamps starting close to the wrap ----
    apply_cfg(16'hFFFF, 8'hFF);
    clock_ms = 32'hFFF0_0000;
    rand_items(100);

    apply_cfg(16'd37, 8'd1);
    rand_items(120);

    apply_cfg(16'd1200, 8'd5);
    rand_items(130);

    drain();
    repeat (END_CYC) @(posedge clk);

    $display("Covered %0d requests under %0d register settings, %0d results checked.",
             n_sent, n_settings, n_checked);
    $display("Seen: %0d hazard starts, %0d short and %0d long presses, %0d restart requests.",
             n_hazard, n_short, n_long, n_restart);
    if (n_fail == 0 && n_pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
